[src/compressed_line_page_size_binning_macros.svh]
// assertion macros for the line and page size binning block
// expects signals named clock and reset in the scope of each use
`ifndef COMPRESSED_LINE_PAGE_SIZE_BINNING_MACROS_SVH
`define COMPRESSED_LINE_PAGE_SIZE_BINNING_MACROS_SVH
`ifndef SYNTH
`define CPSB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define CPSB_ASSERT_NEXT(label, cond, nxt, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);
`else
`define CPSB_ASSERT(label, prop, msg)
`define CPSB_ASSERT_NEXT(label, cond, nxt, msg)
`endif
`endif

[src/cpsb_pkg.sv]
// shared types, constants and classification functions for line/page binning
// no dependencies
`timescale 1ns / 1ps

package cpsb_pkg;

   localparam int LinesPerPageDef = 64;
   localparam int CounterWidthDef = 64;

   localparam int LineClasses  = 4;
   localparam int PageClasses  = 8;
   localparam int LineClassW   = 2;
   localparam int PageClassW   = 3;
   localparam int SizeW        = 10;
   localparam int PageBitsW    = 16;
   localparam int StatIdxW     = 6;
   localparam int StatW        = 64;
   localparam int SumW         = 13;
   localparam int SlotBytesW   = 7;
   localparam int BitsPerByte  = 8;
   localparam int MetaBytes    = 64;
   localparam int PageStepBytes = 512;
   localparam int SlotMaxBytes = 64;

   localparam int RspFifoDepth = 4;
   localparam int RspPtrW      = $clog2(RspFifoDepth);
   localparam int RspCountW    = $clog2(RspFifoDepth + 1);

   // operation codes
   localparam logic OpPush = 1'b0;
   localparam logic OpRead = 1'b1;

   // line slot classes
   localparam logic [LineClassW-1:0] LineClass0  = 2'd0;
   localparam logic [LineClassW-1:0] LineClass8  = 2'd1;
   localparam logic [LineClassW-1:0] LineClass32 = 2'd2;
   localparam logic [LineClassW-1:0] LineClass64 = 2'd3;

   // statistic groups, taken from stat_index[5:3]
   localparam logic [2:0] StatGrpLine      = 3'd0;
   localparam logic [2:0] StatGrpPageCnt   = 3'd1;
   localparam logic [2:0] StatGrpPageBits  = 3'd2;
   localparam logic [2:0] StatGrpPageAlign = 3'd3;

   typedef struct packed {
      logic [LineClassW-1:0] line_class;
      logic                  page_done;
      logic [PageClassW-1:0] page_class;
      logic [PageBitsW-1:0]  page_alloc_bits;
      logic [PageBitsW-1:0]  page_aligned_bits;
      logic [StatW-1:0]      stat_value;
   } rsp_payload_type;

   typedef struct packed {
      logic [RspCountW-1:0] count;
   } fifo_status_type;

   function automatic logic [SlotBytesW-1:0] slot_bytes(input logic [LineClassW-1:0] lc);
      logic [SlotBytesW-1:0] b;
      case (lc)
         LineClass0:  b = 7'd0;
         LineClass8:  b = 7'd8;
         LineClass32: b = 7'd32;
         default:     b = 7'd64;
      endcase
      return b;
   endfunction

   function automatic logic [LineClassW-1:0] line_class_of(input logic is_zero,
                                                           input logic [SizeW-1:0] size);
      logic [LineClassW-1:0] lc;
      if (is_zero || size == '0) begin
         lc = LineClass0;
      end else if (size <= SizeW'(8 * BitsPerByte)) begin
         lc = LineClass8;
      end else if (size <= SizeW'(32 * BitsPerByte)) begin
         lc = LineClass32;
      end else begin
         lc = LineClass64;
      end
      return lc;
   endfunction

   // first 512-byte step strictly above the sum, clamped to the last one
   function automatic logic [PageClassW-1:0] page_class_of(input logic [SumW-1:0] sum);
      logic [SumW-1:0] steps;
      logic [PageClassW-1:0] pc;
      steps = sum / SumW'(PageStepBytes);
      if (steps >= SumW'(PageClasses)) begin
         pc = PageClassW'(PageClasses - 1);
      end else begin
         pc = steps[PageClassW-1:0];
      end
      return pc;
   endfunction

   function automatic logic [PageBitsW-1:0] page_alloc_of(input logic [PageClassW-1:0] pc);
      logic [PageBitsW-1:0] steps;
      steps = PageBitsW'(pc) + PageBitsW'(1);
      return PageBitsW'(steps * PageBitsW'(PageStepBytes * BitsPerByte))
             + PageBitsW'(MetaBytes * BitsPerByte);
   endfunction

endpackage

[src/cpsb_if.sv]
// request and response channel interfaces for line/page binning
// depends on cpsb_pkg
`timescale 1ns / 1ps

interface cpsb_req_if;
   logic                           valid;
   logic                           ready;
   logic                           operation;
   logic [cpsb_pkg::SizeW-1:0]     line_size_bits;
   logic                           line_is_zero;
   logic [cpsb_pkg::SizeW-1:0]     line_norm_bits;
   logic [cpsb_pkg::PageBitsW-1:0] page_bits;
   logic [cpsb_pkg::StatIdxW-1:0]  stat_index;

   modport source (output valid, output operation, output line_size_bits,
                   output line_is_zero, output line_norm_bits, output page_bits,
                   output stat_index, input ready);
   modport sink (input valid, input operation, input line_size_bits,
                 input line_is_zero, input line_norm_bits, input page_bits,
                 input stat_index, output ready);
endinterface

interface cpsb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cpsb_pkg::LineClassW-1:0] line_class;
   logic                            page_done;
   logic [cpsb_pkg::PageClassW-1:0] page_class;
   logic [cpsb_pkg::PageBitsW-1:0]  page_alloc_bits;
   logic [cpsb_pkg::PageBitsW-1:0]  page_aligned_bits;
   logic [cpsb_pkg::StatW-1:0]      stat_value;

   modport source (output valid, output line_class, output page_done, output page_class,
                   output page_alloc_bits, output page_aligned_bits, output stat_value,
                   input ready);
   modport sink (input valid, input line_class, input page_done, input page_class,
                 input page_alloc_bits, input page_aligned_bits, input stat_value,
                 output ready);
endinterface

[src/cpsb_ram.sv]
// generic single write port, single read port ram with registered read
// depends on cpsb_pkg for default sizes
`timescale 1ns / 1ps

module cpsb_ram #(
   parameter int Width = cpsb_pkg::CounterWidthDef,
   parameter int Depth = cpsb_pkg::LineClasses
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // read returns the old word when the same entry is written in that cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/cpsb_rsp_fifo.sv]
// response queue between the counter update stage and the response channel
// depends on cpsb_pkg
`timescale 1ns / 1ps

module cpsb_rsp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  cpsb_pkg::rsp_payload_type push_data,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output cpsb_pkg::rsp_payload_type pop_data,
   output cpsb_pkg::fifo_status_type status
);

   localparam int Depth  = cpsb_pkg::RspFifoDepth;
   localparam int PtrW   = cpsb_pkg::RspPtrW;
   localparam int CountW = cpsb_pkg::RspCountW;

   cpsb_pkg::rsp_payload_type mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              pop;

   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + CountW'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid    = (count_ff != '0);
   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;

endmodule

[src/compressed_line_page_size_binning.sv]
// Line and page size binning. Each request either pushes one compressed cacheline
// size or reads one statistic counter; every request gives exactly one response.
// A new request is taken every cycle. The per-class counters live in two small
// memories (line classes, page classes) with registered reads: a request reads
// its counter entries in the cycle it is accepted, and a push writes the line
// entry back (the page entry only on a page's last line) in the next one, with
// the last write forwarded to a request reading the same entry right behind it.
// Responses go through the stage-1 register and a four-entry queue that absorbs
// response-side stalls; requests wait only when it could overflow. Counters
// read as zero after reset through per-entry valid flags, so no clearing pass.
// depends on cpsb_pkg, cpsb_if, cpsb_ram, cpsb_rsp_fifo and the macros header
`timescale 1ns / 1ps
`include "compressed_line_page_size_binning_macros.svh"

module compressed_line_page_size_binning #(
   parameter int LinesPerPage = cpsb_pkg::LinesPerPageDef,
   parameter int CounterWidth = cpsb_pkg::CounterWidthDef
) (
   input logic        clock,
   input logic        reset,
   cpsb_req_if.sink   req_chan,
   cpsb_rsp_if.source rsp_chan
);

   localparam int LipW      = (LinesPerPage > 1) ? $clog2(LinesPerPage) : 1;
   localparam int SumW      = cpsb_pkg::SumW;
   localparam int LineCW    = cpsb_pkg::LineClassW;
   localparam int PageCW    = cpsb_pkg::PageClassW;
   localparam int SizeW     = cpsb_pkg::SizeW;
   localparam int PageBitsW = cpsb_pkg::PageBitsW;
   localparam int StatIdxW  = cpsb_pkg::StatIdxW;
   localparam int StatW     = cpsb_pkg::StatW;
   localparam int CountW    = cpsb_pkg::RspCountW;
   localparam int LineW     = 2 * CounterWidth;
   localparam int PageW     = 3 * CounterWidth;

   typedef struct packed {
      logic                  push;
      logic [LineCW-1:0]     line_class;
      logic                  page_done;
      logic [PageCW-1:0]     page_class;
      logic [PageBitsW-1:0]  aligned_bits;
      logic [SizeW-1:0]      norm_bits;
      logic [PageBitsW-1:0]  page_bits;
      logic [StatIdxW-1:0]   stat_index;
      logic [LineCW-1:0]     line_addr;
      logic [PageCW-1:0]     page_addr;
      logic                  line_entry_valid;
      logic                  page_entry_valid;
   } s1_type;

   // stage 0: classify and read counters
   logic                  req_fire;
   logic                  is_push;
   logic                  last_line;
   logic [LineCW-1:0]     lc0;
   logic [SumW-1:0]       sum_next;
   logic [PageCW-1:0]     pc0;
   logic [LineCW-1:0]     line_raddr;
   logic [PageCW-1:0]     page_raddr;
   logic [LipW-1:0]       line_in_page_ff, line_in_page_in;
   logic [SumW-1:0]       aligned_sum_ff, aligned_sum_in;
   logic [cpsb_pkg::LineClasses-1:0] line_valid_ff;
   logic [cpsb_pkg::PageClasses-1:0] page_valid_ff;

   // stage 1: update and write back
   logic       s1_valid_ff;
   s1_type     s1_ff, s1_in;
   logic [LineW-1:0] line_rdata, line_old, line_wdata;
   logic [PageW-1:0] page_rdata, page_old, page_wdata;
   logic             line_we, page_we;
   logic             lw_line_valid_ff;
   logic [LineCW-1:0] lw_line_addr_ff;
   logic [LineW-1:0]  lw_line_data_ff;
   logic             lw_page_valid_ff;
   logic [PageCW-1:0] lw_page_addr_ff;
   logic [PageW-1:0]  lw_page_data_ff;
   logic [CounterWidth-1:0] line_cnt_old, line_bits_old;
   logic [CounterWidth-1:0] page_cnt_old, page_bits_old, page_align_old;
   logic [CounterWidth-1:0] stat_sel;
   cpsb_pkg::rsp_payload_type rsp_in, rsp_out;
   cpsb_pkg::fifo_status_type fifo_status;
   logic [CountW:0]   occupancy;

   // the queue must have room for everything already in flight
   assign occupancy      = {1'b0, fifo_status.count} + (CountW + 1)'(s1_valid_ff);
   assign req_chan.ready = (occupancy <= (CountW + 1)'(cpsb_pkg::RspFifoDepth - 1));
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign is_push        = (req_chan.operation == cpsb_pkg::OpPush);

   always_comb begin
      lc0        = cpsb_pkg::line_class_of(req_chan.line_is_zero, req_chan.line_size_bits);
      sum_next   = aligned_sum_ff + SumW'(cpsb_pkg::slot_bytes(lc0));
      pc0        = cpsb_pkg::page_class_of(sum_next);
      last_line  = (line_in_page_ff == LipW'(LinesPerPage - 1));
      line_raddr = is_push ? lc0 : req_chan.stat_index[LineCW-1:0];
      page_raddr = is_push ? pc0 : req_chan.stat_index[PageCW-1:0];

      line_in_page_in = line_in_page_ff;
      aligned_sum_in  = aligned_sum_ff;
      if (req_fire && is_push) begin
         if (last_line) begin
            line_in_page_in = '0;
            aligned_sum_in  = '0;
         end else begin
            line_in_page_in = line_in_page_ff + LipW'(1);
            aligned_sum_in  = sum_next;
         end
      end

      s1_in.push             = is_push;
      s1_in.line_class       = lc0;
      s1_in.page_done        = is_push && last_line;
      s1_in.page_class       = pc0;
      s1_in.aligned_bits     = PageBitsW'({sum_next, 3'b000});
      s1_in.norm_bits        = req_chan.line_norm_bits;
      s1_in.page_bits        = req_chan.page_bits;
      s1_in.stat_index       = req_chan.stat_index;
      s1_in.line_addr        = line_raddr;
      s1_in.page_addr        = page_raddr;
      s1_in.line_entry_valid = line_valid_ff[line_raddr];
      s1_in.page_entry_valid = page_valid_ff[page_raddr];
   end

   cpsb_ram #(.Width(LineW), .Depth(cpsb_pkg::LineClasses)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (s1_ff.line_addr),
      .wr_data (line_wdata),
      .rd_addr (line_raddr),
      .rd_data (line_rdata)
   );

   cpsb_ram #(.Width(PageW), .Depth(cpsb_pkg::PageClasses)) u_page_ram (
      .clock   (clock),
      .wr_en   (page_we),
      .wr_addr (s1_ff.page_addr),
      .wr_data (page_wdata),
      .rd_addr (page_raddr),
      .rd_data (page_rdata)
   );

   always_comb begin
      // forward the write made in the cycle this request read the ram
      if (lw_line_valid_ff && lw_line_addr_ff == s1_ff.line_addr) begin
         line_old = lw_line_data_ff;
      end else if (s1_ff.line_entry_valid) begin
         line_old = line_rdata;
      end else begin
         line_old = '0;
      end
      if (lw_page_valid_ff && lw_page_addr_ff == s1_ff.page_addr) begin
         page_old = lw_page_data_ff;
      end else if (s1_ff.page_entry_valid) begin
         page_old = page_rdata;
      end else begin
         page_old = '0;
      end

      line_cnt_old   = line_old[CounterWidth-1:0];
      line_bits_old  = line_old[LineW-1:CounterWidth];
      page_cnt_old   = page_old[CounterWidth-1:0];
      page_bits_old  = page_old[2*CounterWidth-1:CounterWidth];
      page_align_old = page_old[PageW-1:2*CounterWidth];

      line_we    = s1_valid_ff && s1_ff.push;
      page_we    = s1_valid_ff && s1_ff.page_done;
      line_wdata = {line_bits_old + CounterWidth'(s1_ff.norm_bits),
                    line_cnt_old + CounterWidth'(1)};
      page_wdata = {page_align_old + CounterWidth'(s1_ff.aligned_bits),
                    page_bits_old + CounterWidth'(s1_ff.page_bits),
                    page_cnt_old + CounterWidth'(1)};

      unique case (s1_ff.stat_index[StatIdxW-1:3])
         cpsb_pkg::StatGrpLine:      stat_sel = s1_ff.stat_index[2] ? line_bits_old
                                                                    : line_cnt_old;
         cpsb_pkg::StatGrpPageCnt:   stat_sel = page_cnt_old;
         cpsb_pkg::StatGrpPageBits:  stat_sel = page_bits_old;
         cpsb_pkg::StatGrpPageAlign: stat_sel = page_align_old;
         default:                    stat_sel = '0;
      endcase

      rsp_in = '0;
      if (s1_ff.push) begin
         rsp_in.line_class = s1_ff.line_class;
         if (s1_ff.page_done) begin
            rsp_in.page_done         = 1'b1;
            rsp_in.page_class        = s1_ff.page_class;
            rsp_in.page_alloc_bits   = cpsb_pkg::page_alloc_of(s1_ff.page_class);
            rsp_in.page_aligned_bits = s1_ff.aligned_bits;
         end
      end else begin
         rsp_in.stat_value = StatW'(stat_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_in_page_ff  <= '0;
         aligned_sum_ff   <= '0;
         line_valid_ff    <= '0;
         page_valid_ff    <= '0;
         s1_valid_ff      <= 1'b0;
         lw_line_valid_ff <= 1'b0;
         lw_page_valid_ff <= 1'b0;
      end else begin
         line_in_page_ff  <= line_in_page_in;
         aligned_sum_ff   <= aligned_sum_in;
         s1_valid_ff      <= req_fire;
         lw_line_valid_ff <= line_we;
         lw_page_valid_ff <= page_we;
         if (line_we) begin
            line_valid_ff[s1_ff.line_addr] <= 1'b1;
         end
         if (page_we) begin
            page_valid_ff[s1_ff.page_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ff           <= s1_in;
      lw_line_addr_ff <= s1_ff.line_addr;
      lw_line_data_ff <= line_wdata;
      lw_page_addr_ff <= s1_ff.page_addr;
      lw_page_data_ff <= page_wdata;
   end

   cpsb_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid_ff),
      .push_data  (rsp_in),
      .pop_valid  (rsp_chan.valid),
      .pop_ready  (rsp_chan.ready),
      .pop_data   (rsp_out),
      .status     (fifo_status)
   );

   assign rsp_chan.line_class        = rsp_out.line_class;
   assign rsp_chan.page_done         = rsp_out.page_done;
   assign rsp_chan.page_class        = rsp_out.page_class;
   assign rsp_chan.page_alloc_bits   = rsp_out.page_alloc_bits;
   assign rsp_chan.page_aligned_bits = rsp_out.page_aligned_bits;
   assign rsp_chan.stat_value        = rsp_out.stat_value;

   `CPSB_ASSERT(a_rsp_queue_room, s1_valid_ff |-> (fifo_status.count < CountW'(cpsb_pkg::RspFifoDepth)), "response queue overflow")
   `CPSB_ASSERT_NEXT(a_page_restart, req_fire && is_push && last_line, (line_in_page_ff == '0) && (aligned_sum_ff == '0), "page state not cleared after last line")
   `CPSB_ASSERT(a_sum_bound, aligned_sum_ff <= SumW'(cpsb_pkg::SlotMaxBytes * LinesPerPage), "aligned byte sum out of range")

endmodule
